>>> src/mgps_pkg.sv
package mgps_pkg;

  localparam int unsigned WordW = 32;

  // Request kinds carried on the result channel
  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_FENCE  = 3'd2;
  localparam logic [2:0] KIND_WAIT   = 3'd3;
  localparam logic [2:0] KIND_FINISH = 3'd4;

  // Completion actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_WAIT  = 2'd3;

  // Finish stage codes
  localparam logic [3:0] STAGE_RUN          = 4'd0;
  localparam logic [3:0] STAGE_PRE_TIMEOUT  = 4'd1;
  localparam logic [3:0] STAGE_PRE_UNKNOWN  = 4'd2;
  localparam logic [3:0] STAGE_PRE_STALL    = 4'd3;
  localparam logic [3:0] STAGE_WR_REFUSED   = 4'd4;
  localparam logic [3:0] STAGE_CMD_TIMEOUT  = 4'd5;
  localparam logic [3:0] STAGE_CMD_UNKNOWN  = 4'd6;
  localparam logic [3:0] STAGE_CMD_STALL    = 4'd7;
  localparam logic [3:0] STAGE_REJECTED     = 4'd8;
  localparam logic [3:0] STAGE_MISMATCH     = 4'd9;
  localparam logic [3:0] STAGE_OPEN         = 4'd10;

  // Mailbox response codes that end a poll
  localparam logic [WordW-1:0] RESP_OK    = 32'h0000_0001;
  localparam logic [WordW-1:0] RESP_ERR_A = 32'h0000_00ff;
  localparam logic [WordW-1:0] RESP_ERR_B = 32'h0000_00fe;
  localparam logic [WordW-1:0] RESP_ERR_C = 32'h0000_00fd;
  localparam logic [WordW-1:0] RESP_ERR_D = 32'h0000_00fc;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESP_ADDR = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ARG_ADDR  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CMD_ADDR  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_QUERY_ARG = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MSG_CODE  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_EXPECTED  = 3'd7;

  // One queued result; fence_first asks for a fence beat ahead of it
  typedef struct packed {
    logic [2:0]       kind;
    logic [WordW-1:0] addr;
    logic [WordW-1:0] data;
    logic [3:0]       stage;
    logic [WordW-1:0] poll_total;
    logic [WordW-1:0] first_response;
    logic [WordW-1:0] command_response;
    logic [WordW-1:0] readback_value;
    logic             gate_open;
    logic             fence_first;
  } entry_t;

  function automatic logic is_terminal(input logic [WordW-1:0] v);
    return (v == RESP_OK) || (v == RESP_ERR_A) || (v == RESP_ERR_B) ||
           (v == RESP_ERR_C) || (v == RESP_ERR_D);
  endfunction

endpackage

>>> src/mgps_if.sv
interface mgps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] read_value;
  logic        accepted;
  logic [31:0] start_poll_count;

  modport source (output valid, action, read_value, accepted, start_poll_count,
                  input ready);
  modport sink (input valid, action, read_value, accepted, start_poll_count,
                output ready);
endinterface

interface mgps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  request_kind;
  logic [31:0] request_addr;
  logic [31:0] request_data;
  logic [3:0]  stage_code;
  logic [31:0] poll_total;
  logic [31:0] first_response;
  logic [31:0] command_response;
  logic [31:0] readback_value;
  logic        gate_open;
  logic        last;

  modport source (output valid, request_kind, request_addr, request_data, stage_code,
                  poll_total, first_response, command_response, readback_value,
                  gate_open, last, input ready);
  modport sink (input valid, request_kind, request_addr, request_data, stage_code,
                poll_total, first_response, command_response, readback_value,
                gate_open, last, output ready);
endinterface

interface mgps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/mgps_out_fifo.sv
module mgps_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mgps_pkg::entry_t entry_i,
  output logic            full_o,
  mgps_out_if.source      out_o
);
  import mgps_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       fence_sent_q;
  entry_t     head;
  logic       show_fence, beat, pop;

  assign head       = mem_q[rd_ptr_q];
  assign full_o     = (count_q == 2'd2);
  assign show_fence = head.fence_first && !fence_sent_q;
  assign beat       = out_o.valid && out_o.ready;
  assign pop        = beat && !show_fence;

  assign out_o.valid            = (count_q != 2'd0);
  assign out_o.request_kind     = show_fence ? KIND_FENCE : head.kind;
  assign out_o.request_addr     = show_fence ? '0 : head.addr;
  assign out_o.request_data     = show_fence ? '0 : head.data;
  assign out_o.stage_code       = show_fence ? STAGE_RUN : head.stage;
  assign out_o.poll_total       = head.poll_total;
  assign out_o.first_response   = head.first_response;
  assign out_o.command_response = head.command_response;
  assign out_o.readback_value   = head.readback_value;
  assign out_o.gate_open        = show_fence ? 1'b0 : head.gate_open;
  assign out_o.last             = !show_fence;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= 1'b0;
      rd_ptr_q     <= 1'b0;
      count_q      <= 2'd0;
      fence_sent_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q     <= ~rd_ptr_q;
        fence_sent_q <= 1'b0;
      end else if (beat) begin
        fence_sent_q <= 1'b1;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

>>> src/mailbox_gate_probe_sequencer.sv
// The result of an accepted item is written into the result queue and offered from there.
// Items are taken one per cycle while the result queue is not full; the command-write
// step yields a fence beat and a write beat on the result channel.
// A two-entry result queue sets the depth of decoupling between the two channels.
// Reset: phase idle, counters, saved responses and all configuration registers zero,
// result queue empty.
module mailbox_gate_probe_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mgps_cfg_if.sink    cfg_i,
  mgps_in_if.sink     in_i,
  mgps_out_if.source  out_o
);
  import mgps_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE_POLL, PH_PRE_WAIT, PH_WR_CLEAR, PH_WR_ARG,
    PH_WR_CMD, PH_CMD_POLL, PH_CMD_WAIT, PH_ARG_READ, PH_DONE
  } phase_e;

  // Configuration registers
  logic [WordW-1:0] timeout_q, interval_q, resp_addr_q, arg_addr_q;
  logic [WordW-1:0] cmd_addr_q, query_arg_q, msg_code_q, expected_q;

  // Sequencer state
  phase_e           phase_q, phase_d;
  logic [WordW-1:0] elapsed_q, elapsed_d;
  logic [WordW-1:0] poll_q, poll_d;
  logic [WordW-1:0] first_q, first_d;
  logic [WordW-1:0] cmd_resp_q, cmd_resp_d;
  logic [WordW-1:0] readback_q, readback_d;

  logic   in_beat, emit, fifo_full, pre, polling;
  entry_t res;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !fifo_full;
  assign in_beat     = in_i.valid && in_i.ready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= '0;
      interval_q  <= '0;
      resp_addr_q <= '0;
      arg_addr_q  <= '0;
      cmd_addr_q  <= '0;
      query_arg_q <= '0;
      msg_code_q  <= '0;
      expected_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_TIMEOUT:   timeout_q   <= cfg_i.data;
        REG_INTERVAL:  interval_q  <= cfg_i.data;
        REG_RESP_ADDR: resp_addr_q <= cfg_i.data;
        REG_ARG_ADDR:  arg_addr_q  <= cfg_i.data;
        REG_CMD_ADDR:  cmd_addr_q  <= cfg_i.data;
        REG_QUERY_ARG: query_arg_q <= cfg_i.data;
        REG_MSG_CODE:  msg_code_q  <= cfg_i.data;
        REG_EXPECTED:  expected_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign pre     = (phase_q == PH_PRE_POLL);
  assign polling = pre || (phase_q == PH_CMD_POLL);

  // Step logic: decide next state and the request to issue for one completion.
  // Result snapshot fields always carry the updated state.
  always_comb begin
    logic [2:0]       kind;
    logic [WordW-1:0] addr, data;
    logic [3:0]       stage;
    logic             fence;

    phase_d    = phase_q;
    elapsed_d  = elapsed_q;
    poll_d     = poll_q;
    first_d    = first_q;
    cmd_resp_d = cmd_resp_q;
    readback_d = readback_q;
    emit       = 1'b0;
    kind       = KIND_READ;
    addr       = '0;
    data       = '0;
    stage      = STAGE_RUN;
    fence      = 1'b0;

    unique case (in_i.action)
      ACT_START: begin
        // Restart from any phase
        poll_d     = in_i.start_poll_count;
        elapsed_d  = '0;
        first_d    = '0;
        cmd_resp_d = '0;
        readback_d = '0;
        phase_d    = PH_PRE_POLL;
        emit       = 1'b1;
        kind       = KIND_READ;
        addr       = resp_addr_q;
      end
      ACT_READ: begin
        if (polling) begin
          emit   = 1'b1;
          poll_d = poll_q + 32'd1;
          if (pre) first_d = in_i.read_value;
          else     cmd_resp_d = in_i.read_value;
          if (is_terminal(in_i.read_value)) begin
            if (pre) begin
              // Mailbox idle: clear the response register
              phase_d = PH_WR_CLEAR;
              kind    = KIND_WRITE;
              addr    = resp_addr_q;
            end else if (in_i.read_value != RESP_OK) begin
              phase_d = PH_DONE;
              kind    = KIND_FINISH;
              stage   = STAGE_REJECTED;
            end else begin
              phase_d = PH_ARG_READ;
              kind    = KIND_READ;
              addr    = arg_addr_q;
            end
          end else if (in_i.read_value != '0) begin
            phase_d = PH_DONE;
            kind    = KIND_FINISH;
            stage   = pre ? STAGE_PRE_UNKNOWN : STAGE_CMD_UNKNOWN;
          end else if (elapsed_q >= timeout_q) begin
            phase_d = PH_DONE;
            kind    = KIND_FINISH;
            stage   = pre ? STAGE_PRE_TIMEOUT : STAGE_CMD_TIMEOUT;
          end else begin
            // Still busy: wait one poll interval
            phase_d = pre ? PH_PRE_WAIT : PH_CMD_WAIT;
            kind    = KIND_WAIT;
            data    = interval_q;
          end
        end else if (phase_q == PH_ARG_READ) begin
          emit       = 1'b1;
          readback_d = in_i.read_value;
          phase_d    = PH_DONE;
          kind       = KIND_FINISH;
          stage      = (in_i.read_value == expected_q) ? STAGE_OPEN : STAGE_MISMATCH;
        end
      end
      ACT_WRITE: begin
        if (phase_q == PH_WR_CLEAR || phase_q == PH_WR_ARG || phase_q == PH_WR_CMD) begin
          emit = 1'b1;
          if (!in_i.accepted) begin
            phase_d = PH_DONE;
            kind    = KIND_FINISH;
            stage   = STAGE_WR_REFUSED;
          end else if (phase_q == PH_WR_CLEAR) begin
            phase_d = PH_WR_ARG;
            kind    = KIND_WRITE;
            addr    = arg_addr_q;
            data    = query_arg_q;
          end else if (phase_q == PH_WR_ARG) begin
            // Fence ahead of the command write
            phase_d = PH_WR_CMD;
            kind    = KIND_WRITE;
            addr    = cmd_addr_q;
            data    = msg_code_q;
            fence   = 1'b1;
          end else begin
            phase_d   = PH_CMD_POLL;
            elapsed_d = '0;
            kind      = KIND_READ;
            addr      = resp_addr_q;
          end
        end
      end
      ACT_WAIT: begin
        if (phase_q == PH_PRE_WAIT || phase_q == PH_CMD_WAIT) begin
          emit = 1'b1;
          if (!in_i.accepted) begin
            phase_d = PH_DONE;
            kind    = KIND_FINISH;
            stage   = (phase_q == PH_PRE_WAIT) ? STAGE_PRE_STALL : STAGE_CMD_STALL;
          end else begin
            elapsed_d = elapsed_q + interval_q;
            phase_d   = (phase_q == PH_PRE_WAIT) ? PH_PRE_POLL : PH_CMD_POLL;
            kind      = KIND_READ;
            addr      = resp_addr_q;
          end
        end
      end
      default: ;
    endcase

    res.kind             = kind;
    res.addr             = addr;
    res.data             = data;
    res.stage            = stage;
    res.poll_total       = poll_d;
    res.first_response   = first_d;
    res.command_response = cmd_resp_d;
    res.readback_value   = readback_d;
    res.gate_open        = (kind == KIND_FINISH) && (stage == STAGE_OPEN);
    res.fence_first      = fence;
  end

  // Advance state only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elapsed_q  <= '0;
      poll_q     <= '0;
      first_q    <= '0;
      cmd_resp_q <= '0;
      readback_q <= '0;
    end else if (in_beat) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      poll_q     <= poll_d;
      first_q    <= first_d;
      cmd_resp_q <= cmd_resp_d;
      readback_q <= readback_d;
    end
  end

  // Result queue; expands a fenced entry into two beats
  mgps_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_beat && emit),
    .entry_i (res),
    .full_o  (fifo_full),
    .out_o   (out_o)
  );

endmodule

>>> test/tb.sv
import mgps_pkg::*;

typedef enum logic [3:0] {
  P_IDLE, P_PRE_POLL, P_PRE_WAIT, P_WR_CLEAR, P_WR_ARG, P_WR_CMD,
  P_CMD_POLL, P_CMD_WAIT, P_ARG_READ, P_DONE
} probe_phase_e;

typedef struct packed {
  logic [1:0]  action;
  logic [31:0] read_value;
  logic        accepted;
  logic [31:0] start_poll_count;
} completion_t;

typedef struct packed {
  logic [2:0]  kind;
  logic [31:0] addr;
  logic [31:0] data;
  logic [3:0]  stage;
  logic [31:0] polls;
  logic [31:0] first_resp;
  logic [31:0] cmd_resp;
  logic [31:0] readback;
  logic        gate_open;
  logic        last_flag;
} request_t;

class probe_scoreboard;
  logic [31:0]  timeout_us, interval_us, resp_addr, arg_addr, cmd_addr;
  logic [31:0]  query_word, msg_word, expected_value;
  probe_phase_e step_phase;
  logic [31:0]  elapsed_us, poll_count, first_resp, cmd_resp, readback;
  request_t     expected_q[$];
  int           produced;
  int           errors;

  function new();
    timeout_us = '0; interval_us = '0; resp_addr = '0; arg_addr = '0;
    cmd_addr = '0; query_word = '0; msg_word = '0; expected_value = '0;
    step_phase = P_IDLE;
    elapsed_us = '0; poll_count = '0; first_resp = '0; cmd_resp = '0; readback = '0;
    produced = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_TIMEOUT:   timeout_us = v;
      REG_INTERVAL:  interval_us = v;
      REG_RESP_ADDR: resp_addr = v;
      REG_ARG_ADDR:  arg_addr = v;
      REG_CMD_ADDR:  cmd_addr = v;
      REG_QUERY_ARG: query_word = v;
      REG_MSG_CODE:  msg_word = v;
      default:       expected_value = v;
    endcase
  endfunction

  function void push(logic [2:0] kind, logic [31:0] addr, logic [31:0] data,
                     logic [3:0] stage, logic last_flag);
    request_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.stage = stage;
    r.polls = poll_count;
    r.first_resp = first_resp;
    r.cmd_resp = cmd_resp;
    r.readback = readback;
    r.gate_open = (kind == KIND_FINISH) && (stage == STAGE_OPEN);
    r.last_flag = last_flag;
    expected_q.push_back(r);
  endfunction

  function void finish_probe(logic [3:0] stage);
    step_phase = P_DONE;
    push(KIND_FINISH, '0, '0, stage, 1'b1);
  endfunction

  function bit ends_poll(logic [31:0] v);
    return v == RESP_OK || v == RESP_ERR_A || v == RESP_ERR_B ||
           v == RESP_ERR_C || v == RESP_ERR_D;
  endfunction

  function void take_response(logic [31:0] v, bit pre);
    poll_count = poll_count + 32'd1;
    if (pre) first_resp = v;
    else cmd_resp = v;
    if (ends_poll(v)) begin
      if (pre) begin
        step_phase = P_WR_CLEAR;
        push(KIND_WRITE, resp_addr, '0, STAGE_RUN, 1'b1);
      end else if (v != RESP_OK) begin
        finish_probe(STAGE_REJECTED);
      end else begin
        step_phase = P_ARG_READ;
        push(KIND_READ, arg_addr, '0, STAGE_RUN, 1'b1);
      end
    end else if (v != '0) begin
      finish_probe(pre ? STAGE_PRE_UNKNOWN : STAGE_CMD_UNKNOWN);
    end else if (elapsed_us >= timeout_us) begin
      finish_probe(pre ? STAGE_PRE_TIMEOUT : STAGE_CMD_TIMEOUT);
    end else begin
      step_phase = pre ? P_PRE_WAIT : P_CMD_WAIT;
      push(KIND_WAIT, '0, interval_us, STAGE_RUN, 1'b1);
    end
  endfunction

  function void note_completion(completion_t c);
    int before_n;
    before_n = expected_q.size();
    case (c.action)
      ACT_START: begin
        poll_count = c.start_poll_count;
        elapsed_us = '0;
        first_resp = '0;
        cmd_resp = '0;
        readback = '0;
        step_phase = P_PRE_POLL;
        push(KIND_READ, resp_addr, '0, STAGE_RUN, 1'b1);
      end
      ACT_READ: begin
        case (step_phase)
          P_PRE_POLL: take_response(c.read_value, 1'b1);
          P_CMD_POLL: take_response(c.read_value, 1'b0);
          P_ARG_READ: begin
            readback = c.read_value;
            finish_probe(c.read_value == expected_value ? STAGE_OPEN : STAGE_MISMATCH);
          end
          default: ;
        endcase
      end
      ACT_WRITE: begin
        if (step_phase == P_WR_CLEAR || step_phase == P_WR_ARG || step_phase == P_WR_CMD) begin
          if (!c.accepted) begin
            finish_probe(STAGE_WR_REFUSED);
          end else if (step_phase == P_WR_CLEAR) begin
            step_phase = P_WR_ARG;
            push(KIND_WRITE, arg_addr, query_word, STAGE_RUN, 1'b1);
          end else if (step_phase == P_WR_ARG) begin
            step_phase = P_WR_CMD;
            push(KIND_FENCE, '0, '0, STAGE_RUN, 1'b0);
            push(KIND_WRITE, cmd_addr, msg_word, STAGE_RUN, 1'b1);
          end else begin
            step_phase = P_CMD_POLL;
            elapsed_us = '0;
            push(KIND_READ, resp_addr, '0, STAGE_RUN, 1'b1);
          end
        end
      end
      default: begin
        if (step_phase == P_PRE_WAIT || step_phase == P_CMD_WAIT) begin
          if (!c.accepted) begin
            finish_probe(step_phase == P_PRE_WAIT ? STAGE_PRE_STALL : STAGE_CMD_STALL);
          end else begin
            elapsed_us = elapsed_us + interval_us;
            step_phase = (step_phase == P_PRE_WAIT) ? P_PRE_POLL : P_CMD_POLL;
            push(KIND_READ, resp_addr, '0, STAGE_RUN, 1'b1);
          end
        end
      end
    endcase
    produced = expected_q.size() - before_n;
  endfunction

  task report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task cmp(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got 0x%08h want 0x%08h", field, got, want));
  endtask

  task check_request(request_t got);
    request_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("request beat of kind %0d with nothing pending", got.kind));
      return;
    end
    want = expected_q.pop_front();
    cmp("request_kind", 32'(got.kind), 32'(want.kind));
    cmp("request_addr", got.addr, want.addr);
    cmp("request_data", got.data, want.data);
    cmp("stage_code", 32'(got.stage), 32'(want.stage));
    cmp("poll_total", got.polls, want.polls);
    cmp("first_response", got.first_resp, want.first_resp);
    cmp("command_response", got.cmd_resp, want.cmd_resp);
    cmp("readback_value", got.readback, want.readback);
    cmp("gate_open", 32'(got.gate_open), 32'(want.gate_open));
    cmp("last", 32'(got.last_flag), 32'(want.last_flag));
  endtask
endclass

module tb;
  localparam int ItemsPerPhase = 250;
  localparam int NumPhases     = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [11:0] rx_cyc = '0;
  int burst_left = 0;

  probe_scoreboard sb = new();

  mgps_cfg_if cfg_if ();
  mgps_in_if  in_if ();
  mgps_out_if out_if ();

  mailbox_gate_probe_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: cycle through four stall patterns, chosen by bits 9:8 of a counter - always
  // ready, coin flip, one stall in four, and stretches that stall more often than not.
  always @(negedge clk_i) begin
    rx_cyc <= rx_cyc + 12'd1;
    case (rx_cyc[9:8])
      2'd0:    out_if.ready <= 1'b1;
      2'd1:    out_if.ready <= 1'($urandom_range(0, 1));
      2'd2:    out_if.ready <= (rx_cyc[1:0] != 2'd0);
      default: out_if.ready <= (rx_cyc[3:0] >= 4'd10);
    endcase
  end

  // Monitor: note each accepted completion beat in the predictor and check each
  // accepted request beat against the oldest pending expectation.
  always @(posedge clk_i) begin : monitor
    completion_t seen_c;
    request_t    seen_r;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen_c.action           = in_if.action;
        seen_c.read_value       = in_if.read_value;
        seen_c.accepted         = in_if.accepted;
        seen_c.start_poll_count = in_if.start_poll_count;
        sb.note_completion(seen_c);
      end
      if (out_if.valid && out_if.ready) begin
        seen_r.kind       = out_if.request_kind;
        seen_r.addr       = out_if.request_addr;
        seen_r.data       = out_if.request_data;
        seen_r.stage      = out_if.stage_code;
        seen_r.polls      = out_if.poll_total;
        seen_r.first_resp = out_if.first_response;
        seen_r.cmd_resp   = out_if.command_response;
        seen_r.readback   = out_if.readback_value;
        seen_r.gate_open  = out_if.gate_open;
        seen_r.last_flag  = out_if.last;
        sb.check_request(seen_r);
      end
    end
  end

  function automatic completion_t mk(logic [1:0] action, logic [31:0] rv, logic acc,
                                     logic [31:0] spc);
    completion_t c;
    c.action = action;
    c.read_value = rv;
    c.accepted = acc;
    c.start_poll_count = spc;
    return c;
  endfunction

  // Response word for a poll: most often empty (keeps the probe polling), then
  // success, error codes, and unknown words both near the codes and anywhere.
  function automatic logic [31:0] pick_response();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return '0;
    if (r < 6) return RESP_OK;
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return RESP_ERR_A;
        1:       return RESP_ERR_B;
        2:       return RESP_ERR_C;
        default: return RESP_ERR_D;
      endcase
    end
    if (r == 8) return $urandom_range(RESP_OK + 1, RESP_ERR_D - 1);
    return $urandom();
  endfunction

  // Answer the request the predictor says is outstanding, with random content;
  // one beat in sixteen is noise (any action, possibly a restart mid-probe).
  function automatic completion_t next_completion();
    completion_t c;
    c = mk(ACT_START, $urandom(), 1'($urandom_range(0, 1)), $urandom());
    if ($urandom_range(0, 7) == 0) c.start_poll_count = 32'hffff_ffff - $urandom_range(0, 3);
    if ($urandom_range(0, 15) == 0) begin
      c.action = 2'($urandom_range(0, 3));
      return c;
    end
    case (sb.step_phase)
      P_PRE_POLL, P_CMD_POLL: begin
        c.action = ACT_READ;
        c.read_value = pick_response();
      end
      P_PRE_WAIT, P_CMD_WAIT: begin
        c.action = ACT_WAIT;
        c.accepted = ($urandom_range(0, 19) != 0);
      end
      P_WR_CLEAR, P_WR_ARG, P_WR_CMD: begin
        c.action = ACT_WRITE;
        c.accepted = ($urandom_range(0, 15) != 0);
      end
      P_ARG_READ: begin
        c.action = ACT_READ;
        if ($urandom_range(0, 2) != 0) c.read_value = sb.expected_value;
      end
      default: c.action = ACT_START;
    endcase
    return c;
  endfunction

  // Send one completion beat. Open a new burst when the old one runs out,
  // dropping valid for a random gap first (or not at all, for back-to-back bursts).
  task automatic send(input completion_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_if.valid            <= 1'b1;
    in_if.action           <= c.action;
    in_if.read_value       <= c.read_value;
    in_if.accepted         <= c.accepted;
    in_if.start_poll_count <= c.start_poll_count;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Drop valid, wait out every pending request beat, then give the block a few
  // more cycles in case the last beat it took was one that makes no result.
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (sb.expected_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_all(input logic [31:0] tmo, input logic [31:0] ivl,
                             input logic [31:0] ra, input logic [31:0] aa,
                             input logic [31:0] ca, input logic [31:0] qa,
                             input logic [31:0] mc, input logic [31:0] ev);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_INTERVAL, ivl);
    write_reg(REG_RESP_ADDR, ra);
    write_reg(REG_ARG_ADDR, aa);
    write_reg(REG_CMD_ADDR, ca);
    write_reg(REG_QUERY_ARG, qa);
    write_reg(REG_MSG_CODE, mc);
    write_reg(REG_EXPECTED, ev);
  endtask

  // Count only beats that made the block issue something; ignored ones don't.
  task automatic run_random(input int n);
    int done_n;
    done_n = 0;
    while (done_n < n) begin
      send(next_completion());
      if (sb.produced != 0) done_n++;
    end
  endtask

  initial begin : stimulus
    logic [31:0] iv;
    in_if.valid = 1'b0;
    in_if.action = ACT_START;
    in_if.read_value = '0;
    in_if.accepted = 1'b0;
    in_if.start_poll_count = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_TIMEOUT;
    cfg_if.data = '0;

    // Hold reset, then release it on a falling edge.
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: timeout of 20 us against a 7 us interval, so the fourth
    // empty poll of the preflight times out.
    program_all(32'd20, 32'd7, 32'h1000_0010, 32'h1000_0014, 32'h1000_0018,
                32'hdead_0001, 32'h0000_00a5, 32'h5a5a_c3c3);
    // Preflight timeout, with the poll counter wrapping on its first read.
    send(mk(ACT_START, '0, 1'b0, 32'hffff_ffff));
    send(mk(ACT_READ, '0, 1'b0, '0));
    send(mk(ACT_WAIT, '0, 1'b1, '0));
    send(mk(ACT_READ, '0, 1'b0, '0));
    send(mk(ACT_WAIT, '0, 1'b1, '0));
    send(mk(ACT_READ, '0, 1'b0, '0));
    send(mk(ACT_WAIT, '0, 1'b1, '0));
    send(mk(ACT_READ, '0, 1'b0, '0));
    // A completion after the finish must be ignored.
    send(mk(ACT_WRITE, 32'hffff_ffff, 1'b1, 32'hffff_ffff));
    // Error code ends the preflight, then a failed wait during the command poll.
    send(mk(ACT_START, '0, 1'b1, '0));
    send(mk(ACT_READ, RESP_ERR_A, 1'b0, '0));
    send(mk(ACT_WRITE, '0, 1'b1, '0));
    send(mk(ACT_WRITE, '0, 1'b1, '0));
    send(mk(ACT_WRITE, '0, 1'b1, '0));
    send(mk(ACT_READ, '0, 1'b0, '0));
    send(mk(ACT_WAIT, '0, 1'b0, '0));
    // Full successful probe ending with the gate open.
    send(mk(ACT_START, '0, 1'b0, 32'h0000_0100));
    send(mk(ACT_READ, RESP_OK, 1'b0, '0));
    send(mk(ACT_WRITE, '0, 1'b1, '0));
    send(mk(ACT_WRITE, '0, 1'b1, '0));
    send(mk(ACT_WRITE, '0, 1'b1, '0));
    send(mk(ACT_READ, RESP_OK, 1'b0, '0));
    send(mk(ACT_READ, 32'h5a5a_c3c3, 1'b0, '0));
    // Unknown response during the preflight.
    send(mk(ACT_START, '0, 1'b0, 32'h7fff_ffff));
    send(mk(ACT_READ, RESP_OK + 1, 1'b0, '0));

    // Random part: advance through settings - all zero, all ones, short
    // timeouts with small intervals, and large values that wrap elapsed time.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph % 4)
        0: program_all('0, '0, '0, '0, '0, '0, '0, '0);
        1: program_all('1, '1, '1, '1, '1, '1, '1, '1);
        2: begin
          iv = $urandom_range(0, 64);
          program_all(iv * $urandom_range(0, 4), iv, $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom_range(0, 3));
        end
        default: program_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom());
      endcase
      run_random(ItemsPerPhase);
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
